// ===== sv/b64enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64enc_pkg
// Types, constants and the sextet-to-character map for the base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64enc_pkg;

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } b64_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } b64_out_t;

  // One closed group as handed from front to back.
  // pad_cnt: number of trailing '=' characters (0, 1 or 2).
  typedef struct packed {
    logic [23:0] grp;
    logic [1:0]  pad_cnt;
    logic        last;
  } b64_grp_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/b64enc_front.sv =====
// ----------------------------------------------------------------------------
// b64enc_front
// Gathers input bytes into groups of three and closes short groups on the
// last byte of a message, pushing each closed group into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_front
  import b64enc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire b64_in_t  in_data,
  output logic          push,
  output b64_grp_t      push_data,
  input  wire logic     q_full
);

  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic        acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    push      = 1'b0;
    push_data = '{grp: {pend_r, in_data.in_byte}, pad_cnt: 2'd0,
                  last: in_data.last_byte};
    if (acc) begin
      if (cnt_r == 2'd2) begin
        push    = 1'b1;
        cnt_nxt = 2'd0;
        pend_nxt = '0;
      end else if (!in_data.last_byte) begin
        if (cnt_r == 2'd1) begin
          pend_nxt = {pend_r[15:8], in_data.in_byte};
          cnt_nxt  = 2'd2;
        end else begin
          pend_nxt = {in_data.in_byte, 8'h00};
          cnt_nxt  = 2'd1;
        end
      end else begin
        push     = 1'b1;
        cnt_nxt  = 2'd0;
        pend_nxt = '0;
        if (cnt_r == 2'd1) begin
          push_data.grp     = {pend_r[15:8], in_data.in_byte, 8'h00};
          push_data.pad_cnt = 2'd1;
        end else begin
          push_data.grp     = {in_data.in_byte, 16'h0000};
          push_data.pad_cnt = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      pend_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/b64enc_fifo.sv =====
// ----------------------------------------------------------------------------
// b64enc_fifo
// Short group queue between front and back; DEPTH is a power of two >= 2.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_fifo
  import b64enc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire b64_grp_t push_data,
  output logic          full,
  input  wire logic     pop,
  output b64_grp_t      pop_data,
  output logic          not_empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  b64_grp_t        ent_r [DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/b64enc_back.sv =====
// ----------------------------------------------------------------------------
// b64enc_back
// Expands one queued group into four characters, one beat per cycle while
// out_ready holds, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_back
  import b64enc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_not_empty,
  input  wire b64_grp_t q_data,
  output logic          pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output b64_out_t      out_data
);

  b64_grp_t   grp_r, grp_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       ov_r, ov_nxt;
  b64_out_t   od_r, od_nxt;
  logic       slot_free, load;
  logic [5:0] sx;
  logic       is_pad;

  assign slot_free = !ov_r || out_ready;
  assign load      = busy_r && slot_free;
  // refill the group register on the same cycle the fourth char goes out
  assign pop       = q_not_empty && (!busy_r || (load && idx_r == 2'd3));

  always_comb begin
    case (idx_r)
      2'd0:    sx = grp_r.grp[23:18];
      2'd1:    sx = grp_r.grp[17:12];
      2'd2:    sx = grp_r.grp[11:6];
      default: sx = grp_r.grp[5:0];
    endcase
    is_pad = (grp_r.pad_cnt == 2'd2 && idx_r[1]) ||
             (grp_r.pad_cnt == 2'd1 && idx_r == 2'd3);
  end

  always_comb begin
    grp_nxt  = grp_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r && !out_ready;
    od_nxt   = od_r;
    if (load) begin
      ov_nxt             = 1'b1;
      od_nxt.out_char    = is_pad ? PAD_CHAR : sextet_char(sx);
      od_nxt.last_char   = grp_r.last && (idx_r == 2'd3);
      idx_nxt            = idx_r + 2'd1;
      if (idx_r == 2'd3) busy_nxt = 1'b0;
    end
    if (pop) begin
      grp_nxt  = q_data;
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
    grp_r <= grp_nxt;
    od_r  <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

`default_nettype wire

// ===== sv/base64_stream_encoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Base64 encoder (A-Z a-z 0-9 + /) over a byte stream.
// ----------------------------------------------------------------------------
// One byte per input beat; last_byte closes the message and pads the final
// group with '=' as needed, and last_char marks the final character. Every
// group of three bytes (or a short final group) gives four output beats, one
// character per cycle from the back end's output register while out_ready
// holds, so the character emitter is the limit on the sustained input rate.
// A front end gathers bytes into groups and a FIFO_DEPTH-entry group queue
// decouples it from the emitter, so bytes keep being taken while characters
// are stalled until the queue fills. The closing byte's group is written to
// the queue, then loaded into the group register, then its first character goes to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder_top
  import b64enc_pkg::*;
#(
  parameter int FIFO_DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire b64_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output b64_out_t      out_data
);

  logic     push, q_full, pop, q_not_empty;
  b64_grp_t push_data, q_data;

  b64enc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  b64enc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .not_empty (q_not_empty)
  );

  b64enc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ===== verif/b64_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_checker
// Watches both channels of the base64 encoder, predicts every output
// character from the accepted bytes and compares them in order.
// ----------------------------------------------------------------------------

module b64_checker
  import b64enc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  b64_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  b64_out_t out_data,
  output int       fail_count,
  output int       chars_due,
  output int       chars_checked
);

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // encoder state as predicted: first held byte in [15:8]
  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  b64_out_t    due_chars[$];
  int          fails;
  int          checked;

  initial begin
    fail_count    = 0;
    chars_due     = 0;
    chars_checked = 0;
    fails         = 0;
    checked       = 0;
    held_bytes    = '0;
    held_count    = '0;
  end

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    byte c;
    c = alphabet[v];
    return c[6:0];
  endfunction

  task automatic push_char(input logic [6:0] c, input logic is_last);
    b64_out_t ch;
    ch.out_char  = c;
    ch.last_char = is_last;
    due_chars = {due_chars, ch};
  endtask

  task automatic encode_beat(input b64_in_t beat);
    logic [23:0] grp;
    if (held_count == 2'd3) held_count = 2'd0;
    if (held_count == 2'd2) begin
      grp = {held_bytes, beat.in_byte};
      push_char(b64_char(grp[23:18]), 1'b0);
      push_char(b64_char(grp[17:12]), 1'b0);
      push_char(b64_char(grp[11:6]), 1'b0);
      push_char(b64_char(grp[5:0]), beat.last_byte);
      held_bytes = '0;
      held_count = '0;
    end else if (!beat.last_byte) begin
      if (held_count == 2'd0) held_bytes = {beat.in_byte, 8'h00};
      else held_bytes = {held_bytes[15:8], beat.in_byte};
      held_count = held_count + 2'd1;
    end else begin
      if (held_count == 2'd0) begin
        grp = {beat.in_byte, 16'h0000};
        push_char(b64_char(grp[23:18]), 1'b0);
        push_char(b64_char(grp[17:12]), 1'b0);
        push_char(PAD_CHAR, 1'b0);
      end else begin
        grp = {held_bytes[15:8], beat.in_byte, 8'h00};
        push_char(b64_char(grp[23:18]), 1'b0);
        push_char(b64_char(grp[17:12]), 1'b0);
        push_char(b64_char(grp[11:6]), 1'b0);
      end
      push_char(PAD_CHAR, 1'b1);
      held_bytes = '0;
      held_count = '0;
    end
  endtask

  always @(posedge clk) begin
    b64_out_t want;
    if (!rst_n) begin
      due_chars.delete();
      held_bytes = '0;
      held_count = '0;
    end else begin
      if (in_valid && in_ready) encode_beat(in_data);
      if (out_valid && out_ready) begin
        if (due_chars.size() == 0) begin
          $display("%0t: unexpected char beat: expected none, got %h last %0b",
                   $time, out_data.out_char, out_data.last_char);
          fails++;
        end else begin
          want = due_chars.pop_front();
          checked++;
          if (out_data.out_char !== want.out_char) begin
            $display("%0t: out_char mismatch: expected %h, got %h",
                     $time, want.out_char, out_data.out_char);
            fails++;
          end
          if (out_data.last_char !== want.last_char) begin
            $display("%0t: last_char mismatch: expected %0b, got %0b",
                     $time, want.last_char, out_data.last_char);
            fails++;
          end
        end
      end
    end
    fail_count    <= fails;
    chars_due     <= due_chars.size();
    chars_checked <= checked;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the base64 stream encoder: directed edge groups,
// then random messages under random idling, back-pressure and a drain pause.
// ----------------------------------------------------------------------------

module tb_top;
  import b64enc_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 20;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  b64_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  b64_out_t out_data;

  int fail_count;
  int chars_due;
  int chars_checked;

  bit src_idle_en;
  bit sink_idle_en;
  int hold_req;
  int hold_ack;
  int beats_sent;
  int msgs_sent;
  int cycle_count;

  base64_stream_encoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  b64_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .chars_due     (chars_due),
    .chars_checked (chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout, %0d chars still due", $time, chars_due);
        $display("** base64_stream_encoder_top: FAILED **");
        $finish;
      end
    end
  end

  // receiver: random ready, or a long hold-off on request
  initial begin
    hold_ack  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else if (sink_idle_en) begin
        out_ready <= ($urandom_range(99) >= 34);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic is_last);
    in_valid          <= 1'b1;
    in_data.in_byte   <= b;
    in_data.last_byte <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    if (is_last) msgs_sent++;
    // each further idle cycle has the same odds as the first, about one in three
    if (src_idle_en && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 34);
    end
  endtask

  // n bytes, first byte in the highest used lane, last one flagged
  task automatic send_bytes(input logic [47:0] data, input int n);
    for (int i = 0; i < n; i++) send_beat(data[8*(n-1-i) +: 8], i == n - 1);
  endtask

  task automatic send_random_msg(input int len);
    for (int i = 0; i < len; i++) send_beat(8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic random_phase(input int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      len = $urandom_range(1, 9);
      send_random_msg(len);
      sent += len;
    end
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_due != 0) @(posedge clk);
  endtask

  initial begin
    hold_req     = 0;
    beats_sent   = 0;
    msgs_sent    = 0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte and two-byte tails, full groups at both extremes
    send_bytes(48'h00, 1);
    send_bytes(48'hFF, 1);
    send_bytes(48'h00FF, 2);
    send_bytes(48'h000000, 3);
    send_bytes(48'hFBFFBF, 3);
    // full group without the flag, then a one-byte tail
    send_bytes(48'h4D616E4D, 4);
    // full group, then a two-byte tail
    send_bytes(48'hFFFFFFFFFF, 5);
    send_bytes(48'h010204081020, 6);

    random_phase(20);

    // no idling on either side
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    random_phase(15);

    // receiver holds off while a long message keeps coming
    hold_req++;
    send_random_msg(16);

    // sender waits for every char before going on
    drain_outputs();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    random_phase(15);

    drain_outputs();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d bytes in %0d messages, %0d chars checked.",
             beats_sent, msgs_sent, chars_checked);
    $display("Covered padding tails, full groups, random idling and a long output stall.");
    if (fail_count == 0) begin
      $display("** base64_stream_encoder_top: PASSED **");
    end else begin
      $display("** base64_stream_encoder_top: FAILED **");
    end
    $finish;
  end

endmodule
